// File: sv/sha_pkg.sv
// Shared types, constants and helper functions for the SHA-256 byte stream hasher.
// Depends on nothing; sha_msg, sha_round and the top level use it by scoped names.
package sha_pkg;

  localparam int unsigned TOTAL_W = 61;
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic       byte_en;
    logic [7:0] byte_val;
    logic       round_en;
    logic [5:0] round_idx;
    logic       fold;
    logic       restart;
  } ctrl_t;

  typedef logic [7:0][31:0] words_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// File: sv/sha_if.sv
// Handshake interfaces for the message byte channel and the digest channel.
// Depends on nothing.
interface sha_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last;

  modport source(output valid, output data_byte, output has_byte, output last,
                 input ready);
  modport sink(input valid, input data_byte, input has_byte, input last,
               output ready);
endinterface

interface sha_digest_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_part0;
  logic [63:0] digest_part1;
  logic [63:0] digest_part2;
  logic [63:0] digest_part3;

  modport source(output valid, output digest_part0, output digest_part1,
                 output digest_part2, output digest_part3, input ready);
  modport sink(input valid, input digest_part0, input digest_part1,
               input digest_part2, input digest_part3, output ready);
endinterface

// File: sv/sha_msg.sv
// Block buffer and message schedule: bytes shift in, then the same register slides
// as the sixteen-word schedule window during the rounds. Depends on sha_pkg.
module sha_msg (
  input  logic          clk,
  input  sha_pkg::ctrl_t ctrl,
  output logic [31:0]   wt
);

  logic [511:0] blk;
  logic [31:0]  w1;
  logic [31:0]  w9;
  logic [31:0]  w14;
  logic [31:0]  s0;
  logic [31:0]  s1;
  logic [31:0]  w_new;

  assign wt  = blk[511:480];
  assign w1  = blk[479:448];
  assign w9  = blk[223:192];
  assign w14 = blk[63:32];
  assign s0  = sha_pkg::rotr(w1, 7) ^ sha_pkg::rotr(w1, 18) ^ (w1 >> 3);
  assign s1  = sha_pkg::rotr(w14, 17) ^ sha_pkg::rotr(w14, 19) ^ (w14 >> 10);
  assign w_new = wt + s0 + w9 + s1;

  always_ff @(posedge clk) begin
    if (ctrl.byte_en) begin
      blk <= {blk[503:0], ctrl.byte_val};
    end else if (ctrl.round_en) begin
      blk <= {blk[479:0], w_new};
    end
  end

endmodule

// File: sv/sha_round.sv
// Compression round unit with the working variables and the chaining hash words.
// Depends on sha_pkg for the round constants, initial values and control struct.
module sha_round (
  input  logic           clk,
  input  logic           rst,
  input  sha_pkg::ctrl_t ctrl,
  input  logic [31:0]    wt,
  output sha_pkg::words_t sums
);

  logic [31:0] hw [8];
  logic [31:0] v [8];
  logic [31:0] big0;
  logic [31:0] big1;
  logic [31:0] ch;
  logic [31:0] maj;
  logic [31:0] t1;
  logic [31:0] t2;

  assign big1 = sha_pkg::rotr(v[4], 6) ^ sha_pkg::rotr(v[4], 11) ^ sha_pkg::rotr(v[4], 25);
  assign ch   = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign t1   = v[7] + big1 + ch + sha_pkg::ROUND_K[ctrl.round_idx] + wt;
  assign big0 = sha_pkg::rotr(v[0], 2) ^ sha_pkg::rotr(v[0], 13) ^ sha_pkg::rotr(v[0], 22);
  assign maj  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign t2   = big0 + maj;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      sums[i] = hw[i] + v[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.restart) begin
      for (int i = 0; i < 8; i++) begin
        hw[i] <= sha_pkg::INIT_H[i];
        v[i]  <= sha_pkg::INIT_H[i];
      end
    end else if (ctrl.fold) begin
      for (int i = 0; i < 8; i++) begin
        hw[i] <= sums[i];
        v[i]  <= sums[i];
      end
    end else if (ctrl.round_en) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

endmodule

// File: sv/sha256_byte_stream_hasher.sv
// Top level of the SHA-256 byte stream hasher: sequencer, padding, byte counts and
// the digest output register. Depends on sha_pkg, sha_if, sha_msg and sha_round.

// A message byte is taken whenever the sequencer is idle, so bytes stream at one
// per cycle until a 64-byte block is full; the byte that fills a block is followed
// by the 64 rounds on the single round unit, then a fold into the hash words.
// An item marked last starts padding, which shifts one pad byte per cycle into the
// block buffer (up to 64, or 72 when the length spills into an extra block), each
// full block again followed by the rounds and the fold; the digest then sits in an
// output register, and the block accepts new bytes while it waits to be taken. A
// last item that finishes while an earlier digest is held waits until it is taken.
module sha256_byte_stream_hasher (
  input  logic clk,
  input  logic rst,
  sha_msg_if.sink      msg,
  sha_digest_if.source digest
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PAD  = 2'd1;
  localparam logic [1:0] ST_COMP = 2'd2;
  localparam logic [1:0] ST_FOLD = 2'd3;

  logic [1:0]                   state;
  logic [5:0]                   fill;
  logic [sha_pkg::TOTAL_W-1:0]  total;
  logic [5:0]                   rnd;
  logic                         pend;
  logic                         mark_done;
  logic                         len_ok;
  logic                         final_blk;
  logic                         out_valid;
  logic [63:0]                  part0;
  logic [63:0]                  part1;
  logic [63:0]                  part2;
  logic [63:0]                  part3;

  sha_pkg::ctrl_t  ctrl;
  sha_pkg::words_t sums;
  logic [31:0]     wt;
  logic            accept;
  logic            out_busy;
  logic            do_fold;
  logic [63:0]     len_shift;
  logic [7:0]      pad_byte;

  assign msg.ready = (state == ST_IDLE);
  assign accept    = msg.valid && msg.ready;
  assign out_busy  = out_valid && !digest.ready;
  assign do_fold   = (state == ST_FOLD) && !(final_blk && out_busy);
  assign len_shift = {total, 3'b000} << {fill[2:0], 3'b000};

  always_comb begin
    priority if (!mark_done) begin
      pad_byte = sha_pkg::PAD_MARK;
    end else if (len_ok && (fill >= sha_pkg::LEN_POS)) begin
      pad_byte = len_shift[63:56];
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    ctrl.byte_en   = 1'b0;
    ctrl.byte_val  = msg.data_byte;
    ctrl.round_en  = (state == ST_COMP);
    ctrl.round_idx = rnd;
    ctrl.fold      = do_fold;
    ctrl.restart   = do_fold && final_blk;
    if (accept && msg.has_byte) begin
      ctrl.byte_en = 1'b1;
    end else if (state == ST_PAD) begin
      ctrl.byte_en  = 1'b1;
      ctrl.byte_val = pad_byte;
    end
  end

  sha_msg u_msg (
    .clk  (clk),
    .ctrl (ctrl),
    .wt   (wt)
  );

  sha_round u_round (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .wt   (wt),
    .sums (sums)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      total     <= '0;
      rnd       <= '0;
      pend      <= 1'b0;
      mark_done <= 1'b0;
      len_ok    <= 1'b0;
      final_blk <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            pend      <= msg.last;
            mark_done <= 1'b0;
            len_ok    <= 1'b0;
            final_blk <= 1'b0;
            if (msg.has_byte) begin
              fill  <= fill + 6'd1;
              total <= total + 1'b1;
            end
            if (msg.has_byte && (fill == sha_pkg::LAST_POS)) begin
              state <= ST_COMP;
              rnd   <= '0;
            end else if (msg.last) begin
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          fill <= fill + 6'd1;
          if (!mark_done) begin
            mark_done <= 1'b1;
            len_ok    <= (fill < sha_pkg::LEN_POS);
          end
          if (fill == sha_pkg::LAST_POS) begin
            final_blk <= mark_done && len_ok;
            state     <= ST_COMP;
            rnd       <= '0;
          end
        end
        ST_COMP: begin
          rnd <= rnd + 6'd1;
          if (rnd == sha_pkg::LAST_ROUND) begin
            state <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          if (do_fold) begin
            if (final_blk) begin
              state     <= ST_IDLE;
              fill      <= '0;
              total     <= '0;
              pend      <= 1'b0;
              final_blk <= 1'b0;
            end else begin
              if (mark_done) begin
                len_ok <= 1'b1;
              end
              state <= pend ? ST_PAD : ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_fold && final_blk) begin
      out_valid <= 1'b1;
    end else if (digest.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_fold && final_blk) begin
      part0 <= {sums[0], sums[1]};
      part1 <= {sums[2], sums[3]};
      part2 <= {sums[4], sums[5]};
      part3 <= {sums[6], sums[7]};
    end
  end

  assign digest.valid        = out_valid;
  assign digest.digest_part0 = part0;
  assign digest.digest_part1 = part1;
  assign digest.digest_part2 = part2;
  assign digest.digest_part3 = part3;

`ifndef SYNTHESIS
  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COMP) && (rnd == sha_pkg::LAST_ROUND) |=> (state == ST_FOLD))
    else $error("Compression did not end after the last round.");

  a_pad_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PAD) |-> pend)
    else $error("Padding runs without a pending end of message.");

  a_final_restart: assert property (@(posedge clk) disable iff (rst)
    do_fold && final_blk |=> digest.valid && (fill == '0) && (total == '0)
      && (state == ST_IDLE))
    else $error("Final block did not present a digest and restart the message.");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_busy |-> !(do_fold && final_blk))
    else $error("Digest register overwritten before it was taken.");
`endif

endmodule

// File: tb/sv/sha256_byte_stream_hasher_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the SHA-256 byte stream hasher: random message streams and
// an internal SHA-256 predictor. Depends on sha_if and the sha256_byte_stream_hasher RTL.
module sha256_byte_stream_hasher_tb;

  localparam int RANDOM_REQS = 850;
  localparam int MIN_MSGS = 12;
  localparam int TAIL_REQS = 120;
  localparam int START_HOLD = 400;
  localparam int LONG_HOLD = 600;
  localparam int HOLD_AT_DIGEST = 10;
  localparam int RATE_PERIOD = 500;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 300;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int LEN_FIELD_POS = 56;
  localparam int BLOCK_BYTES = 64;

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } msg_req_t;

  typedef struct packed {
    logic [63:0] part0;
    logic [63:0] part1;
    logic [63:0] part2;
    logic [63:0] part3;
  } digest_t;

  logic clk = 1'b0;
  logic rst;

  sha_msg_if    msg_ch();
  sha_digest_if dig_ch();

  sha256_byte_stream_hasher u_top (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg_ch),
    .digest (dig_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  msg_req_t pending_reqs [$];
  digest_t  digest_fifo [$];
  msg_req_t cur_req;

  logic [31:0] hash_st [8];
  logic [7:0]  blk_buf [64];
  int          blk_fill;
  logic [60:0] msg_len;

  int errors = 0;
  int n_reqs = 0;
  int n_msgs = 0;
  int n_digests = 0;
  int src_gap = 0;
  int dst_gap = 0;
  int src_pct = 0;
  int dst_pct = 0;
  int src_cycles = 0;
  int dst_cycles = 0;
  int hold_left = START_HOLD;
  int quiet_cycles = 0;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    logic [63:0] dbl;
    dbl = {x, x} >> n;
    return dbl[31:0];
  endfunction

  function automatic void compress_blk();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    for (int i = 0; i < 16; i++) begin
      w[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = hash_st[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + w[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_st[i] = hash_st[i] + v[i];
  endfunction

  function automatic void restart_hash();
    for (int i = 0; i < 8; i++) hash_st[i] = SHA_IV[i];
    blk_fill = 0;
    msg_len = '0;
  endfunction

  function automatic void absorb_request(input msg_req_t r);
    logic [63:0] bit_len;
    digest_t d;
    if (r.has_byte) begin
      blk_buf[blk_fill] = r.data_byte;
      blk_fill++;
      msg_len = msg_len + 1'b1;
      if (blk_fill == BLOCK_BYTES) begin
        compress_blk();
        blk_fill = 0;
      end
    end
    if (r.last) begin
      bit_len = {msg_len, 3'b000};
      blk_buf[blk_fill] = PAD_BYTE;
      blk_fill++;
      // The length no longer fits, so the padding takes one more block.
      if (blk_fill > LEN_FIELD_POS) begin
        for (int i = blk_fill; i < BLOCK_BYTES; i++) blk_buf[i] = 8'h00;
        compress_blk();
        blk_fill = 0;
      end
      for (int i = blk_fill; i < LEN_FIELD_POS; i++) blk_buf[i] = 8'h00;
      for (int i = 0; i < 8; i++) blk_buf[LEN_FIELD_POS + i] = bit_len[63 - 8*i -: 8];
      compress_blk();
      d.part0 = {hash_st[0], hash_st[1]};
      d.part1 = {hash_st[2], hash_st[3]};
      d.part2 = {hash_st[4], hash_st[5]};
      d.part3 = {hash_st[6], hash_st[7]};
      digest_fifo = {digest_fifo, d};
      restart_hash();
    end
  endfunction

  function automatic void add_req(input logic [7:0] b, input logic h, input logic l);
    msg_req_t r;
    r.data_byte = b;
    r.has_byte = h;
    r.last = l;
    pending_reqs = {pending_reqs, r};
    n_reqs++;
  endfunction

  function automatic void add_message(input int len);
    logic fold;
    fold = (len != 0) && ($urandom_range(1) == 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(24) == 0) add_req(8'($urandom_range(255)), 1'b0, 1'b0);
      add_req(8'($urandom_range(255)), 1'b1, fold && (i == len - 1));
    end
    if (!fold) add_req(8'($urandom_range(255)), 1'b0, 1'b1);
    n_msgs++;
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(2))
      0: return 0;
      1: return 6;
      default: return 25;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      msg_ch.valid <= 1'b0;
      msg_ch.data_byte <= 8'h00;
      msg_ch.has_byte <= 1'b0;
      msg_ch.last <= 1'b0;
    end else begin
      if (msg_ch.valid && msg_ch.ready) absorb_request(cur_req);
      src_cycles++;
      if (src_cycles % RATE_PERIOD == 0) src_pct = pick_pct();
      if (!msg_ch.valid || msg_ch.ready) begin
        if (src_gap == 0 && pending_reqs.size() > TAIL_REQS &&
            $urandom_range(99) < src_pct) begin
          src_gap = $urandom_range(18, 1);
        end
        if (src_gap != 0 || pending_reqs.size() == 0) begin
          if (src_gap != 0) src_gap--;
          msg_ch.valid <= 1'b0;
        end else begin
          cur_req = pending_reqs.pop_front();
          msg_ch.valid <= 1'b1;
          msg_ch.data_byte <= cur_req.data_byte;
          msg_ch.has_byte <= cur_req.has_byte;
          msg_ch.last <= cur_req.last;
        end
      end
    end
  end

  always @(posedge clk) begin : digest_mon
    logic [63:0] got [4];
    logic [63:0] want [4];
    digest_t exp_d;
    if (rst) begin
      dig_ch.ready <= 1'b0;
    end else begin
      if (dig_ch.valid && dig_ch.ready) begin
        got[0] = dig_ch.digest_part0;
        got[1] = dig_ch.digest_part1;
        got[2] = dig_ch.digest_part2;
        got[3] = dig_ch.digest_part3;
        if (digest_fifo.size() == 0) begin
          $display("%0t: digest with no request waiting, got %h %h %h %h",
                   $time, got[0], got[1], got[2], got[3]);
          errors++;
        end else begin
          exp_d = digest_fifo.pop_front();
          want[0] = exp_d.part0;
          want[1] = exp_d.part1;
          want[2] = exp_d.part2;
          want[3] = exp_d.part3;
          for (int i = 0; i < 4; i++) begin
            if (got[i] !== want[i]) begin
              $display("%0t: digest_part%0d expected %h, actual %h",
                       $time, i, want[i], got[i]);
              errors++;
            end
          end
        end
        n_digests++;
        if (n_digests == HOLD_AT_DIGEST) hold_left = LONG_HOLD;
      end
      dst_cycles++;
      if (dst_cycles % RATE_PERIOD == 0) dst_pct = pick_pct();
      if (hold_left != 0) begin
        hold_left--;
        dig_ch.ready <= 1'b0;
      end else begin
        if (dst_gap == 0 && pending_reqs.size() > TAIL_REQS &&
            $urandom_range(99) < dst_pct) begin
          dst_gap = $urandom_range(18, 1);
        end
        if (dst_gap != 0) begin
          dst_gap--;
          dig_ch.ready <= 1'b0;
        end else begin
          dig_ch.ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (msg_ch.valid && msg_ch.ready) || (dig_ch.valid && dig_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no request moved for %0d cycles", $time, quiet_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    int sel;
    int len;
    rst = 1'b1;
    msg_ch.valid = 1'b0;
    msg_ch.data_byte = 8'h00;
    msg_ch.has_byte = 1'b0;
    msg_ch.last = 1'b0;
    dig_ch.ready = 1'b0;
    restart_hash();

    // Empty messages back to back, idle requests, one-byte extremes, "abc" and two others.
    add_req(8'h00, 1'b0, 1'b1);
    add_req(8'ha5, 1'b0, 1'b0);
    add_req(8'hff, 1'b0, 1'b1);
    add_req(8'h00, 1'b1, 1'b1);
    add_req(8'hff, 1'b1, 1'b1);
    add_req(8'h61, 1'b1, 1'b0);
    add_req(8'h62, 1'b1, 1'b0);
    add_req(8'h63, 1'b1, 1'b1);
    add_req(8'hff, 1'b0, 1'b0);
    add_req(8'h80, 1'b1, 1'b0);
    add_req(8'h5a, 1'b0, 1'b0);
    add_req(8'h7f, 1'b0, 1'b1);
    add_req(8'h7f, 1'b1, 1'b0);
    add_req(8'h01, 1'b1, 1'b0);
    add_req(8'hfe, 1'b1, 1'b0);
    add_req(8'h3c, 1'b0, 1'b1);

    n_reqs = 0;
    n_msgs = 0;
    while (n_reqs < RANDOM_REQS || n_msgs < MIN_MSGS) begin
      sel = $urandom_range(99);
      if (sel < 45) len = $urandom_range(10);
      else if (sel < 85) len = $urandom_range(66, 53);
      else len = $urandom_range(130, 118);
      add_message(len);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || msg_ch.valid) @(posedge clk);
    while (digest_fifo.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
